// File: rtl/core/fbrs_pkg.sv
// ----------------------------------------------------------------------------
// fbrs_pkg
// Types and constants shared by the base run segmenter and its checker.
// ----------------------------------------------------------------------------
package fbrs_pkg;

  localparam int unsigned MaxChunk  = 65536;
  localparam int unsigned LenW      = 17;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned CfgDataW  = 32;
  localparam int unsigned CfgAddrW  = 2;
  localparam int unsigned OutDataW  = 32;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QPtrW     = $clog2(QueueDepth);
  localparam int unsigned QCntW     = $clog2(QueueDepth + 1);

  localparam logic [LenW-1:0] MaxChunkLen = LenW'(MaxChunk);
  localparam logic [LenW-1:0] LimitReset  = LenW'(65536);

  localparam logic [CfgAddrW-1:0] RegChunkLimit = '0;

  localparam logic KindBase     = 1'b0;
  localparam logic KindChunkEnd = 1'b1;

  localparam logic [ByteW-1:0] ChGt   = 8'h3E;
  localparam logic [ByteW-1:0] ChPlus = 8'h2B;
  localparam logic [ByteW-1:0] ChAt   = 8'h40;
  localparam logic [ByteW-1:0] ChEq   = 8'h3D;
  localparam logic [ByteW-1:0] ChNl   = 8'h0A;
  localparam logic [ByteW-1:0] ChUA   = 8'h41;
  localparam logic [ByteW-1:0] ChUC   = 8'h43;
  localparam logic [ByteW-1:0] ChUG   = 8'h47;
  localparam logic [ByteW-1:0] ChUT   = 8'h54;
  localparam logic [ByteW-1:0] ChUU   = 8'h55;
  localparam logic [ByteW-1:0] ChLa   = 8'h61;
  localparam logic [ByteW-1:0] ChLc   = 8'h63;
  localparam logic [ByteW-1:0] ChLg   = 8'h67;
  localparam logic [ByteW-1:0] ChLt   = 8'h74;
  localparam logic [ByteW-1:0] ChLu   = 8'h75;

  typedef struct packed {
    logic            starts_new;
    logic [LenW-1:0] chunk_length;
    logic [ByteW-1:0] base_char;
    logic            kind;
  } res_t;

  function automatic logic is_base(input logic [ByteW-1:0] c);
    return (c == ChUA) || (c == ChLa) || (c == ChUC) || (c == ChLc) ||
           (c == ChUG) || (c == ChLg) || (c == ChUT) || (c == ChLt) ||
           (c == ChUU) || (c == ChLu);
  endfunction

  function automatic logic is_header_mark(input logic [ByteW-1:0] c);
    return (c == ChGt) || (c == ChPlus) || (c == ChAt) || (c == ChEq);
  endfunction

endpackage

// File: rtl/core/fasta_base_run_segmenter_top.sv
// ----------------------------------------------------------------------------
// fasta_base_run_segmenter_top
// Splits a FASTA/FASTQ byte stream into runs of bases with chunk-end beats.
// ----------------------------------------------------------------------------
// The block takes one byte beat per clock cycle while the input is ready;
// each byte is classified in the cycle it is accepted and yields zero, one
// or two output beats, which enter a four-entry output queue. The input is
// ready whenever that queue holds at most two beats, so with a consumer that
// takes a beat every cycle the block sustains one byte per cycle until bytes
// that yield two beats fill the queue. Beats are offered from the registered queue.
// ----------------------------------------------------------------------------
module fasta_base_run_segmenter_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // APB configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [fbrs_pkg::CfgAddrW-1:0]    paddr,
  input  logic [fbrs_pkg::CfgDataW-1:0]    pwdata,
  output logic [fbrs_pkg::CfgDataW-1:0]    prdata,
  output logic                             pready,
  // Input stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [7:0]                       s_axis_tdata,  // byte_value[7:0]
  input  logic                             s_axis_tlast,  // last_byte
  // Output stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // base_char[7:0], chunk_length[24:8], starts_new[25], zero[31:26]
  output logic [fbrs_pkg::OutDataW-1:0]    m_axis_tdata,
  output logic                             m_axis_tuser   // kind
);
  import fbrs_pkg::*;

  logic [LenW-1:0]  chunk_limit_q;
  logic [LenW-1:0]  limit;
  logic             in_header_q, in_header_d;
  logic [LenW-1:0]  chunk_count_q, chunk_count_d;
  logic             break_seen_q, break_seen_d;
  logic             at_file_start_q, at_file_start_d;

  res_t             res0, res1;
  logic [1:0]       n_res;

  res_t             queue_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] count_q;
  logic             s_fire, m_fire;
  logic [ByteW-1:0] c;

  assign pready = 1'b1;
  assign prdata = (paddr == RegChunkLimit) ? CfgDataW'(chunk_limit_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_limit_q <= LimitReset;
    end else if (psel && penable && pwrite && (paddr == RegChunkLimit)) begin
      chunk_limit_q <= pwdata[LenW-1:0];
    end
  end

  always_comb begin
    if (chunk_limit_q == '0) begin
      limit = LenW'(1);
    end else if (chunk_limit_q > MaxChunkLen) begin
      limit = MaxChunkLen;
    end else begin
      limit = chunk_limit_q;
    end
  end

  assign s_axis_tready = (count_q <= QCntW'(QueueDepth - 2));
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = (count_q != '0);
  assign m_fire        = m_axis_tvalid && m_axis_tready;
  assign c             = s_axis_tdata;

  always_comb begin
    res_t end_res;
    in_header_d     = in_header_q;
    chunk_count_d   = chunk_count_q;
    break_seen_d    = break_seen_q;
    at_file_start_d = 1'b0;
    res0            = '0;
    res1            = '0;
    n_res           = 2'd0;
    end_res         = '0;

    if (in_header_q) begin
      if (c == ChNl) begin
        in_header_d = 1'b0;
      end
    end else if (is_base(c)) begin
      res0.kind      = KindBase;
      res0.base_char = c;
      n_res          = 2'd1;
      chunk_count_d  = chunk_count_q + LenW'(1);
      if (chunk_count_d >= limit) begin
        res1.kind         = KindChunkEnd;
        res1.chunk_length = chunk_count_d;
        res1.starts_new   = break_seen_q;
        n_res             = 2'd2;
        chunk_count_d     = '0;
        break_seen_d      = 1'b0;
      end
    end else if (c == ChNl) begin
      n_res = 2'd0;
    end else begin
      if (chunk_count_q != '0) begin
        res0.kind         = KindChunkEnd;
        res0.chunk_length = chunk_count_q;
        res0.starts_new   = break_seen_q;
        n_res             = 2'd1;
        chunk_count_d     = '0;
        break_seen_d      = 1'b0;
      end
      if (is_header_mark(c)) begin
        in_header_d = 1'b1;
        if (!at_file_start_q) begin
          break_seen_d = 1'b1;
        end
      end else begin
        break_seen_d = 1'b1;
      end
    end

    if (s_axis_tlast) begin
      if (chunk_count_d != '0) begin
        end_res.kind         = KindChunkEnd;
        end_res.chunk_length = chunk_count_d;
        end_res.starts_new   = break_seen_d;
        if (n_res == 2'd0) begin
          res0 = end_res;
        end else begin
          res1 = end_res;
        end
        n_res = n_res + 2'd1;
      end
      in_header_d     = 1'b0;
      chunk_count_d   = '0;
      break_seen_d    = 1'b0;
      at_file_start_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_header_q     <= 1'b0;
      chunk_count_q   <= '0;
      break_seen_q    <= 1'b0;
      at_file_start_q <= 1'b1;
      wr_ptr_q        <= '0;
      rd_ptr_q        <= '0;
      count_q         <= '0;
    end else begin
      if (s_fire) begin
        in_header_q     <= in_header_d;
        chunk_count_q   <= chunk_count_d;
        break_seen_q    <= break_seen_d;
        at_file_start_q <= at_file_start_d;
        wr_ptr_q        <= wr_ptr_q + QPtrW'(n_res);
      end
      if (m_fire) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
      count_q <= count_q + (s_fire ? QCntW'(n_res) : QCntW'(0))
                         - (m_fire ? QCntW'(1) : QCntW'(0));
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire && (n_res != 2'd0)) begin
      queue_q[wr_ptr_q] <= res0;
    end
    if (s_fire && (n_res == 2'd2)) begin
      queue_q[wr_ptr_q + QPtrW'(1)] <= res1;
    end
  end

  always_comb begin
    res_t head;
    head          = queue_q[rd_ptr_q];
    m_axis_tuser  = head.kind;
    m_axis_tdata  = OutDataW'({head.starts_new, head.chunk_length, head.base_char});
  end

endmodule

// File: rtl/core/fbrs_checker.sv
// ----------------------------------------------------------------------------
// fbrs_checker
// Port-level checks on the output stream of the base run segmenter.
// ----------------------------------------------------------------------------
module fbrs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tuser
);
  import fbrs_pkg::*;

  // A stalled beat must stay offered.
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output beat dropped while stalled");

  // A chunk end never reports an empty chunk, and carries no base byte.
  a_end_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KindChunkEnd) |->
      (m_axis_tdata[24:8] != '0) && (m_axis_tdata[7:0] == '0))
    else $error("malformed chunk-end beat");

  // A base beat carries no length and no flag.
  a_base_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KindBase) |-> (m_axis_tdata[31:8] == '0))
    else $error("base beat with stray length or flag");

  // A chunk never exceeds the largest allowed size.
  a_len_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[24:8] <= MaxChunkLen))
    else $error("chunk length above maximum");

endmodule

bind fasta_base_run_segmenter_top fbrs_checker u_fbrs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the FASTA base run segmenter.
// ----------------------------------------------------------------------------
// Byte beats of generated FASTA/FASTQ files are streamed into the block.
// A predictor follows every accepted byte and queues the output beats it
// should cause. Each output beat is checked field by field against the
// oldest queued beat. The chunk limit is rewritten between phases, and the
// valid and ready sides idle at varying rates, including one long stall.
// ----------------------------------------------------------------------------
module tb_top;
  import fbrs_pkg::*;

  typedef struct packed {
    logic             last;
    logic [ByteW-1:0] value;
  } text_byte_t;

  typedef struct packed {
    logic             kind;
    logic [ByteW-1:0] base_char;
    logic [LenW-1:0]  chunk_length;
    logic             starts_new;
  } seg_beat_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [CfgAddrW-1:0] paddr = '0;
  logic [CfgDataW-1:0] pwdata = '0;
  logic [CfgDataW-1:0] prdata;
  logic                pready;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata = '0;
  logic                s_axis_tlast = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tuser;

  fasta_base_run_segmenter_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  text_byte_t      text_q[$];
  seg_beat_t       seg_q[$];
  text_byte_t      next_byte;
  logic            byte_taken = 1'b0;
  int              send_pct = 13;
  int              recv_pct = 86;
  logic            hold_arm = 1'b0;
  logic            hold_on = 1'b0;
  int              err_count = 0;
  int              bytes_in = 0;
  int              beats_out = 0;
  int              chunk_ends = 0;
  int              cfg_writes = 0;
  int              queued_total = 0;

  // Predictor state.
  logic [LenW-1:0] limit_reg = LimitReset;
  logic            skipping_header = 1'b0;
  logic [LenW-1:0] run_len = '0;
  logic            broke = 1'b0;
  logic            file_start = 1'b1;

  always #5 clk_i = ~clk_i;

  function automatic logic is_nucleotide(input logic [ByteW-1:0] b);
    case (b)
      ChUA, ChLa, ChUC, ChLc, ChUG, ChLg, ChUT, ChLt, ChUU, ChLu: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic is_marker(input logic [ByteW-1:0] b);
    case (b)
      ChGt, ChPlus, ChAt, ChEq: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [LenW-1:0] effective_limit();
    if (limit_reg == '0) return LenW'(1);
    if (limit_reg > MaxChunkLen) return MaxChunkLen;
    return limit_reg;
  endfunction

  task automatic close_chunk();
    seg_beat_t e;
    e.kind = KindChunkEnd;
    e.base_char = '0;
    e.chunk_length = run_len;
    e.starts_new = broke;
    seg_q.push_back(e);
    run_len = '0;
    broke = 1'b0;
  endtask

  task automatic predict_byte(input logic [ByteW-1:0] b, input logic last);
    logic      first;
    seg_beat_t e;
    first = file_start;
    file_start = 1'b0;
    bytes_in++;
    if (skipping_header) begin
      if (b == ChNl) skipping_header = 1'b0;
    end else if (is_nucleotide(b)) begin
      e.kind = KindBase;
      e.base_char = b;
      e.chunk_length = '0;
      e.starts_new = 1'b0;
      seg_q.push_back(e);
      run_len = run_len + LenW'(1);
      if (run_len >= effective_limit()) close_chunk();
    end else if (b != ChNl) begin
      if (run_len != '0) close_chunk();
      if (is_marker(b)) begin
        skipping_header = 1'b1;
        if (!first) broke = 1'b1;
      end else begin
        broke = 1'b1;
      end
    end
    if (last) begin
      if (run_len != '0) close_chunk();
      skipping_header = 1'b0;
      run_len = '0;
      broke = 1'b0;
      file_start = 1'b1;
    end
  endtask

  task automatic report_mismatch(input string msg);
    err_count++;
    $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  task automatic check_beat();
    seg_beat_t e;
    beats_out++;
    if (m_axis_tuser == KindChunkEnd) chunk_ends++;
    if (seg_q.size() == 0) begin
      report_mismatch($sformatf("unexpected output beat tuser=%0d tdata=%h",
                                m_axis_tuser, m_axis_tdata));
    end else begin
      e = seg_q.pop_front();
      if (m_axis_tuser !== e.kind)
        report_mismatch($sformatf("beat %0d kind %0d, want %0d",
                                  beats_out, m_axis_tuser, e.kind));
      if (m_axis_tdata[7:0] !== e.base_char)
        report_mismatch($sformatf("beat %0d base_char %h, want %h",
                                  beats_out, m_axis_tdata[7:0], e.base_char));
      if (m_axis_tdata[24:8] !== e.chunk_length)
        report_mismatch($sformatf("beat %0d chunk_length %0d, want %0d",
                                  beats_out, m_axis_tdata[24:8], e.chunk_length));
      if (m_axis_tdata[25] !== e.starts_new)
        report_mismatch($sformatf("beat %0d starts_new %0d, want %0d",
                                  beats_out, m_axis_tdata[25], e.starts_new));
      if (m_axis_tdata[31:26] !== '0)
        report_mismatch($sformatf("beat %0d padding bits %h not zero",
                                  beats_out, m_axis_tdata[31:26]));
    end
  endtask

  always @(posedge clk_i) begin
    byte_taken <= s_axis_tvalid && (s_axis_tready === 1'b1);
    if (rst_ni) begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == RegChunkLimit) limit_reg = pwdata[LenW-1:0];
        cfg_writes++;
      end
      if (m_axis_tvalid && m_axis_tready) check_beat();
      if (s_axis_tvalid && s_axis_tready) predict_byte(s_axis_tdata, s_axis_tlast);
    end
  end

  always @(negedge clk_i) begin
    if (!s_axis_tvalid || byte_taken) begin
      if (text_q.size() != 0 && $urandom_range(99) >= send_pct) begin
        next_byte = text_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= next_byte.value;
        s_axis_tlast  <= next_byte.last;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready <= !hold_on && ($urandom_range(99) >= recv_pct);
  end

  initial begin
    wait (hold_arm);
    hold_on = 1'b1;
    repeat (400) @(posedge clk_i);
    hold_on = 1'b0;
  end

  task automatic push_byte(input logic [ByteW-1:0] b, input logic last);
    text_byte_t t;
    t.value = b;
    t.last = last;
    text_q.push_back(t);
    queued_total++;
  endtask

  task automatic push_text(input string s, input logic last_at_end);
    int i;
    for (i = 0; i < s.len(); i++)
      push_byte(s[i], last_at_end && (i == s.len() - 1));
  endtask

  function automatic logic [ByteW-1:0] pick_base();
    case ($urandom_range(9))
      0: return ChUA;
      1: return ChLa;
      2: return ChUC;
      3: return ChLc;
      4: return ChUG;
      5: return ChLg;
      6: return ChUT;
      7: return ChLt;
      8: return ChUU;
      default: return ChLu;
    endcase
  endfunction

  function automatic logic [ByteW-1:0] pick_marker();
    case ($urandom_range(3))
      0: return ChGt;
      1: return ChPlus;
      2: return ChAt;
      default: return ChEq;
    endcase
  endfunction

  task automatic gen_header(input logic [ByteW-1:0] mark);
    int               n;
    int               i;
    logic [ByteW-1:0] b;
    push_byte(mark, 1'b0);
    n = $urandom_range(0, 10);
    for (i = 0; i < n; i++) begin
      do b = ByteW'($urandom_range(255)); while (b == ChNl);
      push_byte(b, 1'b0);
    end
    push_byte(ChNl, 1'b0);
  endtask

  task automatic gen_seq_line(input int n);
    int i;
    for (i = 0; i < n; i++) begin
      if ($urandom_range(19) == 0) begin
        case ($urandom_range(2))
          0: push_byte("N", 1'b0);
          1: push_byte("n", 1'b0);
          default: push_byte(ByteW'($urandom_range(255)), 1'b0);
        endcase
      end else begin
        push_byte(pick_base(), 1'b0);
      end
    end
    push_byte(ChNl, 1'b0);
  endtask

  task automatic gen_file();
    int recs;
    int r;
    int n;
    int i;
    recs = $urandom_range(1, 4);
    for (r = 0; r < recs; r++) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4: begin
          gen_header(($urandom_range(3) == 0) ? pick_marker() : ChGt);
          n = $urandom_range(1, 3);
          for (i = 0; i < n; i++) gen_seq_line($urandom_range(1, 24));
        end
        5, 6: begin
          n = $urandom_range(1, 20);
          gen_header(ChAt);
          gen_seq_line(n);
          push_byte(ChPlus, 1'b0);
          push_byte(ChNl, 1'b0);
          for (i = 0; i < n; i++) push_byte(ByteW'($urandom_range(33, 126)), 1'b0);
          push_byte(ChNl, 1'b0);
        end
        7: begin
          n = $urandom_range(1, 6);
          for (i = 0; i < n; i++) push_byte(ByteW'($urandom_range(255)), 1'b0);
        end
        default: begin
          n = $urandom_range(1, 2);
          for (i = 0; i < n; i++) gen_seq_line($urandom_range(1, 30));
        end
      endcase
    end
    case ($urandom_range(3))
      0: push_byte(pick_base(), 1'b1);
      1: push_byte(ChNl, 1'b1);
      2: push_byte(ByteW'($urandom_range(255)), 1'b1);
      default: push_byte(pick_marker(), 1'b1);
    endcase
  endtask

  task automatic load_files(input int n);
    int start;
    start = queued_total;
    while (queued_total - start < n) gen_file();
  endtask

  task automatic drain();
    while (text_q.size() != 0 || s_axis_tvalid || seg_q.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [CfgDataW-1:0] v);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= RegChunkLimit;
    pwdata  <= v;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    logic [CfgDataW-1:0] limits [9];
    int                  ph;
    limits[0] = 32'd0;
    limits[1] = 32'd1;
    limits[2] = 32'd3;
    limits[3] = 32'hFFFE_0005;
    limits[4] = 32'd7;
    limits[5] = 32'd65536;
    limits[6] = $urandom_range(2, 40);
    limits[7] = 32'd2;
    limits[8] = 32'd131071;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    @(posedge clk_i);
    push_text(">hA\nACgtUuNNa+q\nG@z\nT", 1'b1);
    drain();
    write_limit(32'd2);
    @(posedge clk_i);
    push_text("=\naCGxtc", 1'b1);
    drain();

    for (ph = 0; ph < 9; ph++) begin
      if (ph < 3) begin
        send_pct = 13;
        recv_pct = 86;
      end else if (ph < 6) begin
        send_pct = 86;
        recv_pct = 13;
      end else begin
        send_pct = 0;
        recv_pct = 0;
      end
      write_limit(limits[ph]);
      @(posedge clk_i);
      load_files(160);
      drain();
    end

    write_limit(32'd5);
    @(posedge clk_i);
    hold_arm = 1'b1;
    load_files(100);
    drain();

    repeat (20) @(posedge clk_i);
    if (seg_q.size() != 0)
      report_mismatch($sformatf("%0d expected beats never arrived", seg_q.size()));
    $display("Run covered %0d input bytes and %0d output beats (%0d chunk ends),",
             bytes_in, beats_out, chunk_ends);
    $display("with %0d chunk limit writes and %0d mismatches.", cfg_writes, err_count);
    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("Timeout: stimulus or expected beats still pending.");
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// File: files.f
rtl/core/fbrs_pkg.sv
rtl/core/fasta_base_run_segmenter_top.sv
rtl/core/fbrs_checker.sv
test/tb_top.sv
